// ===== rtl/core/circular_arc_interpolator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Arc interpolator assertion macros
// Concurrent assertion forms used by the arc interpolator checker.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_ARC_INTERPOLATOR_TOP_DEFINES_SVH
`define CIRCULAR_ARC_INTERPOLATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("arc interpolator: same-cycle property violated");

// The consequent must hold in the cycle after the antecedent.
`define CAI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("arc interpolator: next-cycle property violated");

`endif

// ===== rtl/core/cai_pkg.sv =====
// ----------------------------------------------------------------------------
// Arc interpolator package
// Codes, fixed widths and the control and status structs of the interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cai_pkg;

	// Width of the feed speed field.
	localparam int SPEED_BITS = 16;

	// Item kinds carried in the action field.
	typedef enum logic {
		ACT_START = 1'b0,
		ACT_TICK  = 1'b1
	} cai_action_t;

	// Axis codes.
	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	// Quadrant codes.
	localparam logic [1:0] QUAD_1 = 2'd0;
	localparam logic [1:0] QUAD_2 = 2'd1;
	localparam logic [1:0] QUAD_3 = 2'd2;
	localparam logic [1:0] QUAD_4 = 2'd3;

	// Control handed from the front pipeline to the stepping core.
	typedef struct packed {
		logic go;
		logic tick;
		logic radius_ok;
		logic ccw;
	} cai_ctrl_t;

	// Status flags produced by the stepping core for one item.
	typedef struct packed {
		logic accepted;
		logic rejected;
		logic stepped;
		logic step_axis;
		logic next_axis;
		logic x_positive;
		logic y_positive;
		logic busy;
		logic done;
	} cai_flags_t;

endpackage

// ===== rtl/core/cai_in_if.sv =====
// ----------------------------------------------------------------------------
// Arc interpolator command channel
// Valid/ready channel carrying start and tick items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cai_in_if import cai_pkg::*; #(
	parameter int COORD_BITS = 16
) ();

	logic                         valid;
	logic                         ready;
	logic                         action;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] stop_x;
	logic signed [COORD_BITS-1:0] stop_y;
	logic                         arc_dir;
	logic [SPEED_BITS-1:0]        speed;

	modport source (
		output valid, action, start_x, start_y, stop_x, stop_y, arc_dir, speed,
		input  ready
	);

	modport sink (
		input  valid, action, start_x, start_y, stop_x, stop_y, arc_dir, speed,
		output ready
	);

endinterface

// ===== rtl/core/cai_out_if.sv =====
// ----------------------------------------------------------------------------
// Arc interpolator result channel
// Valid/ready channel carrying one result per command item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cai_out_if import cai_pkg::*; ();

	logic                  valid;
	logic                  ready;
	logic                  accepted;
	logic                  rejected;
	logic                  stepped;
	logic                  step_axis;
	logic                  next_axis;
	logic                  x_positive;
	logic                  y_positive;
	logic                  busy_res;
	logic                  done_res;
	logic [SPEED_BITS-1:0] speed_out;

	modport source (
		output valid, accepted, rejected, stepped, step_axis, next_axis,
		output x_positive, y_positive, busy_res, done_res, speed_out,
		input  ready
	);

	modport sink (
		input  valid, accepted, rejected, stepped, step_axis, next_axis,
		input  x_positive, y_positive, busy_res, done_res, speed_out,
		output ready
	);

endinterface

// ===== rtl/core/circular_arc_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// Circular arc interpolator
// Two-axis point-by-point comparison arc interpolator for stepper drives.
// ----------------------------------------------------------------------------
// Usage:
//   The cmd channel takes start items (action 0: start point, end point,
//   direction and speed) and tick items (action 1: one step pulse from the
//   motor timer). Every transfer on cmd yields exactly one transfer on res.
//   A start is refused while an arc runs, when the two points are not on the
//   same circle, or when they coincide. A tick while idle reports no step.
//   A command passes the stage one, stage two and result registers in turn.
//   Throughput: one item per cycle while results are taken, set by the
//   three-deep pipeline (squares and distances, radius compare and step count,
//   arc state update) that advances as one. When the receiver stalls, the
//   whole pipeline holds and cmd.ready drops until the result is taken.
//   Reset clears the pipeline and returns the arc state to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circular_arc_interpolator_top import cai_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	cai_in_if.sink     cmd,
	cai_out_if.source  res
);

	localparam int SQ_BITS   = 2 * COORD_BITS;
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int STEP_BITS = COORD_BITS + 2;

	logic                         en;

	logic signed [SQ_BITS-1:0]    sq_sx, sq_sy, sq_ex, sq_ey;
	logic signed [DIFF_BITS-1:0]  diff_x, diff_y;
	logic [DIFF_BITS-1:0]         abs_x, abs_y;

	logic                         valid_s1;
	logic                         action_s1;
	logic                         ccw_s1;
	logic signed [COORD_BITS-1:0] sx_s1, sy_s1;
	logic [SPEED_BITS-1:0]        speed_s1;
	logic [SQ_BITS-1:0]           sq_sx_s1, sq_sy_s1, sq_ex_s1, sq_ey_s1;
	logic [DIFF_BITS-1:0]         abs_x_s1, abs_y_s1;

	logic                         valid_s2;
	logic                         action_s2;
	logic                         ccw_s2;
	logic                         radius_ok_s2;
	logic signed [COORD_BITS-1:0] sx_s2, sy_s2;
	logic [SPEED_BITS-1:0]        speed_s2;
	logic [STEP_BITS-1:0]         steps_s2;

	cai_ctrl_t                    ctrl;
	cai_flags_t                   flags;

	logic                         res_valid_q;
	cai_flags_t                   flags_q;
	logic [SPEED_BITS-1:0]        speed_q;

	// The pipeline advances whenever the result register is free or being drained.
	assign en        = !res_valid_q || res.ready;
	assign cmd.ready = en;

	// Squares of both points and per-axis distances, straight from the command.
	always_comb begin
		sq_sx  = cmd.start_x * cmd.start_x;
		sq_sy  = cmd.start_y * cmd.start_y;
		sq_ex  = cmd.stop_x * cmd.stop_x;
		sq_ey  = cmd.stop_y * cmd.stop_y;
		diff_x = DIFF_BITS'(cmd.stop_x) - DIFF_BITS'(cmd.start_x);
		diff_y = DIFF_BITS'(cmd.stop_y) - DIFF_BITS'(cmd.start_y);
		abs_x  = diff_x[DIFF_BITS-1] ? DIFF_BITS'(-diff_x) : DIFF_BITS'(diff_x);
		abs_y  = diff_y[DIFF_BITS-1] ? DIFF_BITS'(-diff_y) : DIFF_BITS'(diff_y);
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= cmd.valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (en) begin
			action_s1 <= cmd.action;
			ccw_s1    <= cmd.arc_dir;
			sx_s1     <= cmd.start_x;
			sy_s1     <= cmd.start_y;
			speed_s1  <= cmd.speed;
			sq_sx_s1  <= SQ_BITS'(sq_sx);
			sq_sy_s1  <= SQ_BITS'(sq_sy);
			sq_ex_s1  <= SQ_BITS'(sq_ex);
			sq_ey_s1  <= SQ_BITS'(sq_ey);
			abs_x_s1  <= abs_x;
			abs_y_s1  <= abs_y;
		end
	end

	// Stage two payload: exact radius compare and the step count.
	always_ff @(posedge clk) begin
		if (en) begin
			action_s2    <= action_s1;
			ccw_s2       <= ccw_s1;
			sx_s2        <= sx_s1;
			sy_s2        <= sy_s1;
			speed_s2     <= speed_s1;
			radius_ok_s2 <= (sq_sx_s1 + sq_sy_s1) == (sq_ex_s1 + sq_ey_s1);
			steps_s2     <= STEP_BITS'(abs_x_s1) + STEP_BITS'(abs_y_s1);
		end
	end

	// Stage two drives the arc state.
	always_comb begin
		ctrl.go        = valid_s2 && en;
		ctrl.tick      = (action_s2 == ACT_TICK);
		ctrl.radius_ok = radius_ok_s2;
		ctrl.ccw       = ccw_s2;
	end

	cai_step_core #(
		.COORD_BITS (COORD_BITS)
	) u_step_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.start_x (sx_s2),
		.start_y (sy_s2),
		.steps   (steps_s2),
		.flags   (flags)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_q <= flags;
			speed_q <= flags.accepted ? speed_s2 : '0;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.accepted   = flags_q.accepted;
	assign res.rejected   = flags_q.rejected;
	assign res.stepped    = flags_q.stepped;
	assign res.step_axis  = flags_q.step_axis;
	assign res.next_axis  = flags_q.next_axis;
	assign res.x_positive = flags_q.x_positive;
	assign res.y_positive = flags_q.y_positive;
	assign res.busy_res   = flags_q.busy;
	assign res.done_res   = flags_q.done;
	assign res.speed_out  = speed_q;

endmodule

// ===== rtl/core/cai_step_core.sv =====
// ----------------------------------------------------------------------------
// Arc interpolator stepping core
// Holds the arc state, decides start acceptance and performs one step per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cai_step_core import cai_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cai_ctrl_t                     ctrl,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic [COORD_BITS+1:0]         steps,
	output cai_flags_t                    flags
);

	localparam int DEV_BITS  = COORD_BITS + 4;
	localparam int STEP_BITS = COORD_BITS + 2;

	// Deviation increment 2*sign*coord+1, with the sign given by the drive direction.
	function automatic logic [DEV_BITS-1:0] dev_term(
		input logic signed [COORD_BITS-1:0] coord,
		input logic                         up
	);
		logic signed [DEV_BITS-1:0] twice;
		twice = DEV_BITS'(coord);
		twice = twice <<< 1;
		return (up ? twice : -twice) + DEV_BITS'(1);
	endfunction

	logic signed [COORD_BITS-1:0] pos_x_q;
	logic signed [COORD_BITS-1:0] pos_y_q;
	logic [DEV_BITS-1:0]          dev_q;
	logic [STEP_BITS-1:0]         steps_left_q;
	logic                         active_q;
	logic [1:0]                   quad_q;
	logic                         ccw_q;
	logic                         x_up_q;
	logic                         y_up_q;
	logic                         running_q;

	logic                         sx_zero, sx_neg, sx_pos;
	logic                         sy_zero, sy_neg, sy_pos;
	logic [1:0]                   quad_n;
	logic                         x_up_n, y_up_n;
	logic                         first_axis;
	logic [DEV_BITS-1:0]          dev_start;
	logic                         start_ok, start_rej, do_tick;
	logic signed [COORD_BITS-1:0] pos_x_n, pos_y_n;
	logic                         nxt_axis;
	logic [DEV_BITS-1:0]          dev_tick;
	logic [STEP_BITS-1:0]         steps_n;
	logic                         last_step;

	// Sign classes of the start point.
	always_comb begin
		sx_zero = (start_x == '0);
		sx_neg  = start_x[COORD_BITS-1];
		sx_pos  = !sx_zero && !sx_neg;
		sy_zero = (start_y == '0);
		sy_neg  = start_y[COORD_BITS-1];
		sy_pos  = !sy_zero && !sy_neg;
	end

	// Quadrant from the start point; points on an axis lean with the arc direction.
	always_comb begin
		if (sx_pos) begin
			if (ctrl.ccw) quad_n = sy_neg ? QUAD_4 : QUAD_1;
			else          quad_n = sy_pos ? QUAD_1 : QUAD_4;
		end else if (sx_neg) begin
			if (ctrl.ccw) quad_n = sy_pos ? QUAD_2 : QUAD_3;
			else          quad_n = sy_neg ? QUAD_3 : QUAD_2;
		end else begin
			if (ctrl.ccw) quad_n = sy_pos ? QUAD_2 : QUAD_4;
			else          quad_n = sy_pos ? QUAD_1 : QUAD_3;
		end
	end

	// Drive directions, first axis and the opening deviation of a new arc.
	always_comb begin
		x_up_n     = ((quad_n == QUAD_1) || (quad_n == QUAD_2)) ^ ctrl.ccw;
		y_up_n     = ((quad_n == QUAD_2) || (quad_n == QUAD_3)) ^ ctrl.ccw;
		first_axis = sx_zero ? AXIS_X : AXIS_Y;
		dev_start  = (first_axis == AXIS_X) ? dev_term(start_x, x_up_n)
		                                    : dev_term(start_y, y_up_n);
	end

	// Item decisions.
	always_comb begin
		start_ok  = ctrl.go && !ctrl.tick && !running_q && ctrl.radius_ok &&
		            (steps != '0);
		start_rej = ctrl.go && !ctrl.tick && !start_ok;
		do_tick   = ctrl.go && ctrl.tick && running_q;
	end

	// One step: move the active axis, pick the next one and update the deviation.
	always_comb begin
		pos_x_n = pos_x_q;
		pos_y_n = pos_y_q;
		if (active_q == AXIS_X) begin
			pos_x_n = x_up_q ? pos_x_q + COORD_BITS'(1) : pos_x_q - COORD_BITS'(1);
		end else begin
			pos_y_n = y_up_q ? pos_y_q + COORD_BITS'(1) : pos_y_q - COORD_BITS'(1);
		end
		nxt_axis  = !dev_q[DEV_BITS-1] ^ ccw_q ^ quad_q[0];
		dev_tick  = dev_q + ((nxt_axis == AXIS_X) ? dev_term(pos_x_n, x_up_q)
		                                          : dev_term(pos_y_n, y_up_q));
		steps_n   = steps_left_q - STEP_BITS'(1);
		last_step = (steps_n == '0);
	end

	// Arc state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			dev_q        <= '0;
			steps_left_q <= '0;
			active_q     <= AXIS_X;
			quad_q       <= QUAD_1;
			ccw_q        <= 1'b0;
			x_up_q       <= 1'b0;
			y_up_q       <= 1'b0;
			running_q    <= 1'b0;
		end else if (start_ok) begin
			pos_x_q      <= start_x;
			pos_y_q      <= start_y;
			dev_q        <= dev_start;
			steps_left_q <= steps;
			active_q     <= first_axis;
			quad_q       <= quad_n;
			ccw_q        <= ctrl.ccw;
			x_up_q       <= x_up_n;
			y_up_q       <= y_up_n;
			running_q    <= 1'b1;
		end else if (do_tick) begin
			pos_x_q      <= pos_x_n;
			pos_y_q      <= pos_y_n;
			dev_q        <= dev_tick;
			steps_left_q <= steps_n;
			active_q     <= nxt_axis;
			running_q    <= !last_step;
		end
	end

	// Status of the item, as seen after its update.
	always_comb begin
		flags.accepted   = start_ok;
		flags.rejected   = start_rej;
		flags.stepped    = do_tick;
		flags.step_axis  = do_tick ? active_q : AXIS_X;
		flags.next_axis  = start_ok ? first_axis : (do_tick ? nxt_axis : active_q);
		flags.x_positive = start_ok ? x_up_n : x_up_q;
		flags.y_positive = start_ok ? y_up_n : y_up_q;
		flags.busy       = start_ok || (do_tick ? !last_step : running_q);
		flags.done       = do_tick && last_step;
	end

endmodule

// ===== rtl/core/cai_checker.sv =====
// ----------------------------------------------------------------------------
// Arc interpolator checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "circular_arc_interpolator_top_defines.svh"

module cai_checker import cai_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  valid,
	input logic                  ready,
	input logic                  accepted,
	input logic                  rejected,
	input logic                  stepped,
	input logic                  busy_res,
	input logic                  done_res,
	input logic [SPEED_BITS-1:0] speed_out
);

	// A stalled result keeps its contents.
	`CAI_ASSERT_NEXT(a_stall_hold, clk, arst_n, valid && !ready, valid && $stable(speed_out) && $stable(accepted) && $stable(stepped))

	// The final step of an arc leaves the block idle.
	`CAI_ASSERT_NOW(a_done_idle, clk, arst_n, valid && done_res, stepped && !busy_res)

	// A start result never also reports a step, and is either taken or refused.
	`CAI_ASSERT_NOW(a_start_kind, clk, arst_n, valid && (accepted || rejected), !stepped && !(accepted && rejected))

	// Speed is passed on only with an accepted start, which always starts an arc.
	`CAI_ASSERT_NOW(a_speed_only_accept, clk, arst_n, valid && !accepted, speed_out == '0)
	`CAI_ASSERT_NOW(a_accept_busy, clk, arst_n, valid && accepted, busy_res)

endmodule

bind circular_arc_interpolator_top cai_checker u_cai_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.valid     (res.valid),
	.ready     (res.ready),
	.accepted  (res.accepted),
	.rejected  (res.rejected),
	.stepped   (res.stepped),
	.busy_res  (res.busy_res),
	.done_res  (res.done_res),
	.speed_out (res.speed_out)
);
